// ----- design/ase_pkg.sv -----
// ----------------------------------------------------------------------------
// ase_pkg: shared types and constants of the arctangent series evaluator
// Holds the sequencer state type, the status codes and the fixed constants
// that the evaluator and its checker both use.
// ----------------------------------------------------------------------------
package ase_pkg;

   localparam int ARG_W    = 32;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 13;
   localparam int STATUS_W = 2;
   localparam int EPS_W    = 31;

   localparam logic [STATUS_W-1:0] STATUS_CONVERGED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SMALL_ARG = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TERM_CAP  = 2'd2;

   // Reset value of the stop threshold, about one millionth in Q0.30.
   localparam logic [EPS_W-1:0] EPSILON_RESET = 31'd1074;

   // The value one in Q16.16.
   localparam logic [ARG_W-1:0] ARG_ONE = 32'h0001_0000;

   // pi/2 with 62 fraction bits.
   localparam logic [63:0] PI_HALF_Q62 = 64'h6487_ED51_10B4_611A;

   // Largest result magnitude in Q2.30.
   localparam logic [VALUE_W-1:0] OUT_LIMIT = 32'd1686629713;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_FIRST,
      ST_NEXT,
      ST_STEP_A,
      ST_STEP_B,
      ST_CHECK,
      ST_ROUND,
      ST_SCALE,
      ST_FINISH
   } state_type;

endpackage

// ----- design/ase_divider.sv -----
// ----------------------------------------------------------------------------
// ase_divider: shared restoring divider
// Produces one quotient bit per cycle. The caller guarantees that the
// quotient fits in QW bits, so only QW steps are run.
// ----------------------------------------------------------------------------
module ase_divider
   import ase_pkg::*;
#(
   parameter int DVW = 63,
   parameter int DSW = 64,
   parameter int QW  = 31
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [DSW-1:0] divisor,
   output logic           done,
   output logic [QW-1:0]  quotient
);

   localparam int CW = $clog2(QW + 1);

   logic [DSW-1:0] rem_ff, rem_in;
   logic [QW-1:0]  quo_ff, quo_in;
   logic [DSW-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;

   logic [DSW:0]   trial;
   logic           take;

   assign trial = {rem_ff, quo_ff[QW-1]};
   assign take  = trial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // The upper part of the dividend is already below the divisor.
         rem_in  = DSW'(dividend >> QW);
         quo_in  = dividend[QW-1:0];
         dsr_in  = divisor;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = take ? DSW'(trial - {1'b0, dsr_ff}) : trial[DSW-1:0];
         quo_in  = {quo_ff[QW-2:0], take};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/arctan_series_evaluator.sv -----
// ----------------------------------------------------------------------------
// arctan_series_evaluator: arctangent of a large argument
// Evaluates sign(x)*pi/2 - 1/x + 1/(3x^3) - ... in fixed point, building each
// term from the last with one shared restoring divider under a sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake               Payload
//   req_      in          req_valid / req_stall   req_argument (Q16.16)
//   rsp_      out         rsp_valid / rsp_stall   rsp_arctan_value (Q2.30),
//                                                 rsp_term_count, rsp_status
//   csr_      in          csr_write_enable        csr_write_data (epsilon)
//
// One item is worked on at a time; req_stall is high from the cycle after an
// item is taken until its result sits in the output register. Every division
// runs FRACTION_BITS+1 steps in the shared divider, and each series term after
// the first needs two of them. An argument whose magnitude is below one skips
// the series and goes from the finish state straight to the output register.
// Reset is synchronous; it clears the sequencer and the output valid and
// returns the epsilon register to its reset value. A stalled result holds in
// the output register while the next item is already being worked.
//
module arctan_series_evaluator
   import ase_pkg::*;
#(
   parameter int MAX_TERMS     = 4096,
   parameter int FRACTION_BITS = 30
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ARG_W-1:0]    req_argument,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [VALUE_W-1:0]  rsp_arctan_value,
   output logic [COUNT_W-1:0]  rsp_term_count,
   output logic [STATUS_W-1:0] rsp_status,

   input  logic                csr_write_enable,
   input  logic [EPS_W-1:0]    csr_write_data
);

   localparam int F    = FRACTION_BITS;
   // Terms never exceed 2^F, so quotients need F+1 bits.
   localparam int QW   = F + 1;
   // The widest dividend is a term shifted up by 32.
   localparam int DVW  = F + 33;
   // The widest divisor is the square of the raw argument.
   localparam int DSW  = 64;
   // The running sum stays below 2^(F+2) in magnitude.
   localparam int SW   = F + 3;
   localparam int NW   = $clog2(MAX_TERMS + 1);
   localparam int UP_T = (F >= 30) ? 0 : 30 - F;
   localparam int UP_E = (F >= 30) ? F - 30 : 0;
   localparam int DN   = (F > 30) ? F - 30 : 0;
   localparam int CMPW = ((F >= 30) ? F : 30) + 2;
   localparam int RW   = SW + UP_T + 1;

   localparam logic [63:0]   PI_HALF_ROUND =
      (PI_HALF_Q62 + (64'd1 << (61 - F))) >> (62 - F);
   localparam logic [SW-1:0] PI_HALF = SW'(PI_HALF_ROUND);
   localparam logic [RW-1:0] ROUND_BIAS = (RW'(1) << DN) >> 1;

   // Sequencer and control.
   state_type state_ff, state_in;

   logic take_input;
   logic load_square;
   logic load_first;
   logic inc_n;
   logic load_step;
   logic set_status;
   logic [STATUS_W-1:0] status_next;
   logic add_pi;
   logic load_scale;
   logic load_rsp;

   logic           div_start;
   logic [DVW-1:0] div_dividend;
   logic [DSW-1:0] div_divisor;
   logic           div_done;
   logic [QW-1:0]  div_quotient;

   // Datapath registers.
   logic [EPS_W-1:0]    epsilon_ff;
   logic [ARG_W-1:0]    mag_ff;
   logic                neg_ff;
   logic [DSW-1:0]      xsq_ff;
   logic [QW-1:0]       t_ff;
   logic                tneg_ff;
   logic signed [SW-1:0] sum_ff;
   logic [NW-1:0]       n_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [RW-1:0]       res_mag_ff;
   logic                res_neg_ff;

   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // Decode of the incoming argument.
   logic               arg_neg;
   logic [ARG_W-1:0]   arg_mag;
   logic               arg_small;

   assign arg_neg   = req_argument[ARG_W-1];
   assign arg_mag   = arg_neg ? (~req_argument + ARG_W'(1)) : req_argument;
   assign arg_small = arg_mag < ARG_ONE;

   // Combinational helpers.
   logic [NW-1:0]       n_plus;
   logic [DSW-1:0]      square;
   logic [CMPW-1:0]     term_cmp;
   logic [CMPW-1:0]     eps_cmp;
   logic                below_eps;
   logic                at_cap;
   logic signed [SW-1:0] q_signed;
   logic                step_neg;
   logic                sum_neg;
   logic [SW-1:0]       sum_mag;
   logic [RW-1:0]       scaled;
   logic [RW-1:0]       sat_mag;
   logic [VALUE_W-1:0]  value_mag;

   assign n_plus    = n_ff + NW'(1);
   assign square    = DSW'(mag_ff) * DSW'(mag_ff);
   assign term_cmp  = CMPW'(t_ff) << UP_T;
   assign eps_cmp   = CMPW'(epsilon_ff) << UP_E;
   assign below_eps = term_cmp < eps_cmp;
   assign at_cap    = n_ff >= NW'(MAX_TERMS);
   assign q_signed  = $signed({{(SW - QW){1'b0}}, div_quotient});
   assign step_neg  = ~tneg_ff;
   assign sum_neg   = sum_ff[SW-1];
   assign sum_mag   = sum_neg ? SW'(-sum_ff) : SW'(sum_ff);
   // Convert to Q2.30: shift up, or round half away from zero on the way down.
   assign scaled    = ((RW'(sum_mag) << UP_T) + ROUND_BIAS) >> DN;
   assign sat_mag   = (res_mag_ff > RW'(OUT_LIMIT)) ? RW'(OUT_LIMIT) : res_mag_ff;
   assign value_mag = VALUE_W'(sat_mag);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = arg_small ? ST_FINISH : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_FIRST;
         end
         ST_FIRST: begin
            if (div_done) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            state_in = ST_STEP_A;
         end
         ST_STEP_A: begin
            if (div_done) begin
               state_in = ST_STEP_B;
            end
         end
         ST_STEP_B: begin
            if (div_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (below_eps || at_cap) ? ST_ROUND : ST_NEXT;
         end
         ST_ROUND: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_stall    = 1'b1;
      take_input   = 1'b0;
      load_square  = 1'b0;
      load_first   = 1'b0;
      inc_n        = 1'b0;
      load_step    = 1'b0;
      set_status   = 1'b0;
      status_next  = STATUS_CONVERGED;
      add_pi       = 1'b0;
      load_scale   = 1'b0;
      load_rsp     = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            take_input = req_valid;
         end
         ST_SQUARE: begin
            // First term magnitude: 2^(F+16) / |X|.
            load_square  = 1'b1;
            div_start    = 1'b1;
            div_dividend = DVW'(1) << (F + 16);
            div_divisor  = DSW'(mag_ff);
         end
         ST_FIRST: begin
            load_first = div_done;
         end
         ST_NEXT: begin
            // floor(t*(2n-1)/(2n+1)) = t - ceil(2t/(2n+1)); the divider gives
            // the ceiling as floor((2t+2n)/(2n+1)).
            inc_n        = 1'b1;
            div_start    = 1'b1;
            div_dividend = DVW'({t_ff, 1'b0}) + DVW'({n_plus, 1'b0});
            div_divisor  = DSW'({n_plus, 1'b1});
         end
         ST_STEP_A: begin
            div_start    = div_done;
            div_dividend = DVW'(t_ff - div_quotient) << 32;
            div_divisor  = xsq_ff;
         end
         ST_STEP_B: begin
            load_step = div_done;
         end
         ST_CHECK: begin
            set_status  = below_eps || at_cap;
            status_next = below_eps ? STATUS_CONVERGED : STATUS_TERM_CAP;
         end
         ST_ROUND: begin
            add_pi = 1'b1;
         end
         ST_SCALE: begin
            load_scale = 1'b1;
         end
         ST_FINISH: begin
            load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   ase_divider #(
      .DVW (DVW),
      .DSW (DSW),
      .QW  (QW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         epsilon_ff   <= EPSILON_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            epsilon_ff <= csr_write_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (take_input) begin
         mag_ff     <= arg_mag;
         neg_ff     <= arg_neg;
         n_ff       <= '0;
         // A small argument goes straight to the output with a zero result.
         res_mag_ff <= '0;
         res_neg_ff <= 1'b0;
         status_ff  <= STATUS_SMALL_ARG;
      end
      if (load_square) begin
         xsq_ff <= square;
      end
      if (load_first) begin
         // The first term is -1/x.
         t_ff    <= div_quotient;
         tneg_ff <= ~neg_ff;
         sum_ff  <= neg_ff ? q_signed : -q_signed;
      end
      if (inc_n) begin
         n_ff <= n_plus;
      end
      if (load_step) begin
         t_ff    <= div_quotient;
         tneg_ff <= step_neg;
         sum_ff  <= step_neg ? (sum_ff - q_signed) : (sum_ff + q_signed);
      end
      if (set_status) begin
         status_ff <= status_next;
      end
      if (add_pi) begin
         sum_ff <= neg_ff ? (sum_ff - $signed(PI_HALF)) : (sum_ff + $signed(PI_HALF));
      end
      if (load_scale) begin
         res_mag_ff <= scaled;
         res_neg_ff <= sum_neg;
      end
      if (load_rsp) begin
         rsp_value_ff  <= res_neg_ff ? (~value_mag + VALUE_W'(1)) : value_mag;
         rsp_count_ff  <= COUNT_W'(n_ff);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_arctan_value = rsp_value_ff;
   assign rsp_term_count   = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ----- design/ase_checker.sv -----
// ----------------------------------------------------------------------------
// ase_checker: port-level checks of the arctangent series evaluator
// Watches the ports of the top level over time; attached by a bind.
// ----------------------------------------------------------------------------
module ase_checker
   import ase_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [ARG_W-1:0]    req_argument,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [VALUE_W-1:0]  rsp_arctan_value,
   input logic [COUNT_W-1:0]  rsp_term_count,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                csr_write_enable
);

   logic req_accept;
   logic small_input;

   assign req_accept  = req_valid && !req_stall;
   assign small_input = (req_argument[ARG_W-1] ? (~req_argument + ARG_W'(1))
                                               : req_argument) < ARG_ONE;

   // A result that is held back stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // The block works on one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("input taken while an item is in flight");

   // An argument below one yields a zero result with no terms.
   a_small_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_SMALL_ARG) |->
         (rsp_arctan_value == '0) && (rsp_term_count == '0))
      else $error("small argument result is not zero");

   // A small argument passes through the finish state into the output register.
   a_small_latency: assert property (@(posedge clock) disable iff (reset)
      req_accept && small_input && !csr_write_enable && !rsp_valid |=> ##1
         (rsp_valid && (rsp_status == STATUS_SMALL_ARG)))
      else $error("small argument result late");

endmodule

bind arctan_series_evaluator ase_checker u_ase_checker (.*);
